// File: design/bbkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbkt_pkg
// Shared types, register indexes and mode codes of the byte block transform.
// ----------------------------------------------------------------------------
package bbkt_pkg;

    localparam int KEY_MAX   = 8;
    localparam int GROUP_MAX = 8;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_KEY_BYTES  = 3'd1;
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd2;
    localparam logic [2:0] CFG_BIG_ENDIAN = 3'd3;
    localparam logic [2:0] CFG_SEQ_START  = 3'd4;
    localparam logic [2:0] CFG_SEQ_END    = 3'd5;
    localparam logic [2:0] CFG_SEQ_STEP   = 3'd6;
    localparam logic [2:0] CFG_SEQ_WSIZE  = 3'd7;

    // Mode codes
    localparam logic [3:0] MODE_XOR   = 4'd0;
    localparam logic [3:0] MODE_ADD   = 4'd1;
    localparam logic [3:0] MODE_SUB   = 4'd2;
    localparam logic [3:0] MODE_MUL   = 4'd3;
    localparam logic [3:0] MODE_REPL  = 4'd4;
    localparam logic [3:0] MODE_DIV   = 4'd5;
    localparam logic [3:0] MODE_SHR   = 4'd6;
    localparam logic [3:0] MODE_SHL   = 4'd7;
    localparam logic [3:0] MODE_OR    = 4'd8;
    localparam logic [3:0] MODE_AND   = 4'd9;
    localparam logic [3:0] MODE_SWAP2 = 4'd10;
    localparam logic [3:0] MODE_SWAP4 = 4'd11;
    localparam logic [3:0] MODE_SWAP8 = 4'd12;
    localparam logic [3:0] MODE_SEQ   = 4'd13;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } t_in;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       bad_key;
    } t_out;

    // Controller -> datapath
    typedef struct packed {
        logic       acc;          // input transaction accepted
        logic       use_port;     // operate on port data, else on latched byte
        logic       div_byte;     // start byte divide
        logic       div_mod;      // start step modulo reduction
        logic       div_step;     // one divider iteration
        logic       load_single;  // commit single result to output register
        logic       load_emit;    // commit one swap buffer entry
        logic [2:0] emit_addr;
        logic       emit_last;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic       swap;
        logic       swap_full;
        logic [3:0] fill_next;
        logic       need_div;
        logic       need_mod;
        logic       div_last;
        logic       out_free;
    } t_sts;

endpackage

// File: design/bbkt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbkt_ctrl
// Sequencer: accepts bytes, runs the divider, drains swap groups.
// ----------------------------------------------------------------------------
module bbkt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  bbkt_pkg::t_sts i_sts,
    output logic           o_in_stall,
    output bbkt_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_eidx, n_eidx;
    logic [3:0] r_en, n_en;
    logic       r_rev, n_rev;
    logic       r_elast, n_elast;
    logic       acc;
    logic       emit_done;

    assign acc        = (r_state == S_IDLE) && i_in_valid && i_sts.out_free;
    assign o_in_stall = !((r_state == S_IDLE) && i_sts.out_free);
    assign emit_done  = ({1'b0, r_eidx} == (r_en - 4'd1));

    always_comb begin
        n_state = r_state;
        n_eidx  = r_eidx;
        n_en    = r_en;
        n_rev   = r_rev;
        n_elast = r_elast;

        o_cmd           = '0;
        o_cmd.acc       = acc;
        o_cmd.use_port  = (r_state == S_IDLE);
        o_cmd.emit_addr = r_rev ? 3'(r_en - 4'd1 - {1'b0, r_eidx}) : r_eidx;
        o_cmd.emit_last = emit_done && r_elast;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_sts.swap) begin
                        if (i_sts.swap_full || i_in_last) begin
                            n_state = S_EMIT;
                            n_eidx  = 3'd0;
                            n_en    = i_sts.fill_next;
                            n_rev   = i_sts.swap_full;
                            n_elast = i_in_last;
                        end
                    end else if (i_sts.need_div) begin
                        o_cmd.div_byte = 1'b1;
                        n_state        = S_DIV;
                    end else if (i_sts.need_mod) begin
                        o_cmd.div_mod = 1'b1;
                        n_state       = S_DIV;
                    end else begin
                        o_cmd.load_single = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_emit = 1'b1;
                    n_eidx          = r_eidx + 3'd1;
                    if (emit_done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eidx  <= 3'd0;
            r_en    <= 4'd0;
            r_rev   <= 1'b0;
            r_elast <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eidx  <= n_eidx;
            r_en    <= n_en;
            r_rev   <= n_rev;
            r_elast <= n_elast;
        end
    end

endmodule

// File: design/bbkt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbkt_dp
// Datapath: config registers, key ops, divider, sequence state, swap buffer.
// ----------------------------------------------------------------------------
module bbkt_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [63:0]     i_cfg_data,
    input  bbkt_pkg::t_in   i_in,
    input  logic            i_out_stall,
    input  bbkt_pkg::t_cmd  i_cmd,
    output bbkt_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output bbkt_pkg::t_out  o_out
);

    // config
    logic [3:0]  r_mode;
    logic [63:0] r_key;
    logic [3:0]  r_key_len;
    logic        r_big;
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [30:0] r_step;
    logic [3:0]  r_wsize;

    // progress
    logic [2:0]  r_key_pos, n_key_pos;
    logic [31:0] r_res, n_res;
    logic [63:0] r_word, n_word;
    logic [2:0]  r_bpos, n_bpos;
    logic [3:0]  r_fill, n_fill;
    logic        r_smod_ok, n_smod_ok;

    // latched input byte
    logic [7:0]  r_din;
    logic        r_lin;

    // divider
    logic [32:0] r_rem;
    logic [30:0] r_dvd;
    logic [32:0] r_dvs;
    logic [7:0]  r_quo;
    logic [4:0]  r_cnt;
    logic        r_div_mod;
    logic [33:0] div_trial;
    logic        div_ge;

    logic [7:0]  r_gbuf [bbkt_pkg::GROUP_MAX];

    logic        r_out_vld;
    bbkt_pkg::t_out r_out;

    // decoded
    logic [7:0]  cur_d;
    logic        cur_last;
    logic        cls_key, cls_swap, cls_seq;
    logic [3:0]  len;
    logic        bad;
    logic [2:0]  kidx;
    logic [7:0]  kbyte;
    logic [7:0]  key_res;
    logic [15:0] prod;
    logic [3:0]  wsize;
    logic [30:0] step;
    logic [3:0]  grp;
    logic [3:0]  fill_next;
    logic        swap_full;
    logic [33:0] diff;
    logic [32:0] dif;
    logic [32:0] res_sum;
    logic [63:0] wsum;
    logic [7:0]  seq_res;
    logic [7:0]  single_d;
    logic        out_free;

    assign cur_d    = i_cmd.use_port ? i_in.data_in : r_din;
    assign cur_last = i_cmd.use_port ? i_in.last_in : r_lin;

    assign cls_key  = (r_mode <= bbkt_pkg::MODE_AND);
    assign cls_swap = (r_mode inside {bbkt_pkg::MODE_SWAP2, bbkt_pkg::MODE_SWAP4,
                                      bbkt_pkg::MODE_SWAP8});
    assign cls_seq  = (r_mode == bbkt_pkg::MODE_SEQ);

    // key length clamp and the reversal check
    always_comb begin
        if (r_key_len == 4'd0) begin
            len = 4'd1;
        end else if (r_key_len > 4'(bbkt_pkg::KEY_MAX)) begin
            len = 4'(bbkt_pkg::KEY_MAX);
        end else begin
            len = r_key_len;
        end
    end

    assign bad   = !r_big && !(len inside {4'd1, 4'd2, 4'd4, 4'd8});
    assign kidx  = r_big ? r_key_pos : 3'(len - 4'd1 - {1'b0, r_key_pos});
    assign kbyte = r_key[{kidx, 3'b000} +: 8];
    assign prod  = cur_d * kbyte;

    always_comb begin
        case (r_mode)
            bbkt_pkg::MODE_XOR:  key_res = cur_d ^ kbyte;
            bbkt_pkg::MODE_ADD:  key_res = cur_d + kbyte;
            bbkt_pkg::MODE_SUB:  key_res = cur_d - kbyte;
            bbkt_pkg::MODE_MUL:  key_res = prod[7:0];
            bbkt_pkg::MODE_REPL: key_res = kbyte;
            bbkt_pkg::MODE_DIV:  key_res = (kbyte == 8'd0) ? 8'd0 : r_quo;
            bbkt_pkg::MODE_SHR:  key_res = (kbyte >= 8'd8) ? 8'd0 : (cur_d >> kbyte[2:0]);
            bbkt_pkg::MODE_SHL:  key_res = (kbyte >= 8'd8) ? 8'd0 : (cur_d << kbyte[2:0]);
            bbkt_pkg::MODE_OR:   key_res = cur_d | kbyte;
            default:             key_res = cur_d & kbyte;
        endcase
    end

    // sequence
    assign wsize = (r_wsize == 4'd0) ? 4'd1 : r_wsize;
    assign step  = (r_step == 31'd0) ? 31'd1 : r_step;
    assign diff  = {{2{r_end[31]}}, r_end} - {{2{r_start[31]}}, r_start} + 34'd1;
    assign dif   = ($signed(r_end) > $signed(r_start)) ? diff[32:0] : 33'd255;
    // r_dvs holds the modulus once the step has been reduced
    assign res_sum = {1'b0, r_res} + {1'b0, r_rem[31:0]};
    assign wsum    = r_word + {{32{r_start[31]}}, r_start};

    always_comb begin
        if (wsize == 4'd1) begin
            seq_res = r_res[7:0] + r_start[7:0];
        end else if (wsize inside {4'd2, 4'd4, 4'd8}) begin
            seq_res = wsum[{r_bpos, 3'b000} +: 8];
        end else begin
            seq_res = cur_d;
        end
    end

    always_comb begin
        if (cls_key) begin
            single_d = bad ? cur_d : key_res;
        end else if (cls_seq) begin
            single_d = seq_res;
        end else begin
            single_d = cur_d;
        end
    end

    // swap group size
    always_comb begin
        case (r_mode)
            bbkt_pkg::MODE_SWAP2: grp = 4'd2;
            bbkt_pkg::MODE_SWAP4: grp = 4'd4;
            default:              grp = 4'd8;
        endcase
    end
    assign fill_next = r_fill + 4'd1;
    assign swap_full = (fill_next == grp);

    // divider iteration
    assign div_trial = {r_rem, r_dvd[30]};
    assign div_ge    = (div_trial >= {1'b0, r_dvs});

    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        o_sts           = '0;
        o_sts.swap      = cls_swap;
        o_sts.swap_full = swap_full;
        o_sts.fill_next = fill_next;
        o_sts.need_div  = cls_key && (r_mode == bbkt_pkg::MODE_DIV) && !bad;
        o_sts.need_mod  = cls_seq && (wsize == 4'd1) && !r_smod_ok;
        o_sts.div_last  = (r_cnt == 5'd1);
        o_sts.out_free  = out_free;
    end

    // progress state
    always_comb begin
        n_key_pos = r_key_pos;
        n_res     = r_res;
        n_word    = r_word;
        n_bpos    = r_bpos;
        n_fill    = r_fill;
        n_smod_ok = r_smod_ok;

        if (i_cfg_we) begin
            n_key_pos = 3'd0;
            n_res     = 32'd0;
            n_word    = 64'd0;
            n_bpos    = 3'd0;
            n_fill    = 4'd0;
            n_smod_ok = 1'b0;
        end else begin
            if (i_cmd.div_step && (r_cnt == 5'd1) && r_div_mod) begin
                n_smod_ok = 1'b1;
            end
            if (i_cmd.acc && cls_swap) begin
                n_fill = (swap_full || i_in.last_in) ? 4'd0 : fill_next;
            end
            if (i_cmd.load_single) begin
                if (cls_key && !bad) begin
                    n_key_pos = ({1'b0, r_key_pos} + 4'd1 >= len) ? 3'd0 : r_key_pos + 3'd1;
                end
                if (cls_seq) begin
                    if (wsize == 4'd1) begin
                        n_res = (res_sum >= r_dvs) ? 32'(res_sum - r_dvs) : res_sum[31:0];
                    end else if (wsize inside {4'd2, 4'd4, 4'd8}) begin
                        if ({1'b0, r_bpos} + 4'd1 >= wsize) begin
                            n_bpos = 3'd0;
                            n_word = r_word + {33'd0, step};
                        end else begin
                            n_bpos = r_bpos + 3'd1;
                        end
                    end
                end
            end
            // block end
            if ((i_cmd.load_single && cur_last) ||
                (i_cmd.acc && cls_swap && i_in.last_in)) begin
                n_key_pos = 3'd0;
                n_res     = 32'd0;
                n_word    = 64'd0;
                n_bpos    = 3'd0;
                n_fill    = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= bbkt_pkg::MODE_XOR;
            r_key     <= 64'd0;
            r_key_len <= 4'd1;
            r_big     <= 1'b0;
            r_start   <= 32'd0;
            r_end     <= 32'd255;
            r_step    <= 31'd1;
            r_wsize   <= 4'd1;
            r_key_pos <= 3'd0;
            r_res     <= 32'd0;
            r_word    <= 64'd0;
            r_bpos    <= 3'd0;
            r_fill    <= 4'd0;
            r_smod_ok <= 1'b0;
            r_cnt     <= 5'd0;
            r_div_mod <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bbkt_pkg::CFG_MODE:       r_mode    <= i_cfg_data[3:0];
                    bbkt_pkg::CFG_KEY_BYTES:  r_key     <= i_cfg_data;
                    bbkt_pkg::CFG_KEY_LENGTH: r_key_len <= i_cfg_data[3:0];
                    bbkt_pkg::CFG_BIG_ENDIAN: r_big     <= i_cfg_data[0];
                    bbkt_pkg::CFG_SEQ_START:  r_start   <= i_cfg_data[31:0];
                    bbkt_pkg::CFG_SEQ_END:    r_end     <= i_cfg_data[31:0];
                    bbkt_pkg::CFG_SEQ_STEP:   r_step    <= i_cfg_data[30:0];
                    bbkt_pkg::CFG_SEQ_WSIZE:  r_wsize   <= i_cfg_data[3:0];
                    default:                  r_mode    <= r_mode;
                endcase
            end
            r_key_pos <= n_key_pos;
            r_res     <= n_res;
            r_word    <= n_word;
            r_bpos    <= n_bpos;
            r_fill    <= n_fill;
            r_smod_ok <= n_smod_ok;

            if (i_cmd.div_byte) begin
                r_cnt     <= 5'd8;
                r_div_mod <= 1'b0;
            end else if (i_cmd.div_mod) begin
                r_cnt     <= 5'd31;
                r_div_mod <= 1'b1;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - 5'd1;
            end

            if (i_cmd.load_single || i_cmd.load_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_din <= i_in.data_in;
            r_lin <= i_in.last_in;
        end
        if (i_cmd.acc && cls_swap) begin
            r_gbuf[r_fill[2:0]] <= i_in.data_in;
        end

        if (i_cmd.div_byte) begin
            r_rem <= 33'd0;
            r_dvd <= {cur_d, 23'd0};
            r_dvs <= {25'd0, kbyte};
        end else if (i_cmd.div_mod) begin
            r_rem <= 33'd0;
            r_dvd <= step;
            r_dvs <= dif;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? 33'(div_trial - {1'b0, r_dvs}) : div_trial[32:0];
            r_dvd <= {r_dvd[29:0], 1'b0};
            r_quo <= {r_quo[6:0], div_ge};
        end

        if (i_cmd.load_single) begin
            r_out.data_out <= single_d;
            r_out.last_out <= cur_last;
            r_out.bad_key  <= cls_key && bad;
        end else if (i_cmd.load_emit) begin
            r_out.data_out <= r_gbuf[i_cmd.emit_addr];
            r_out.last_out <= i_cmd.emit_last;
            r_out.bad_key  <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// File: design/byte_block_key_transform_core.sv
`timescale 1ns / 1ps
// A key, pass-through or sequence byte shows at the output in the cycle after
//   acceptance, one byte per cycle sustained unless the output stalls. Divide mode
//   stalls input while its 8-step restoring divider runs. Only the first byte-word
//   sequence byte after reset or a config write runs a 31-step modulus reduction of the step.
// Swap modes stall input while a full group or block tail (1 to 8 bytes) drains, one
//   byte per cycle unless the output stalls, once the sequencer enters its emit state.
// Reset: synchronous, active low; config and state registers take defaults, no clear pass.
// ----------------------------------------------------------------------------
// byte_block_key_transform_core
// Streams a byte block, combining each byte with a cyclic key, byte-swapping
// groups, or replacing the block with an arithmetic sequence.
// ----------------------------------------------------------------------------
module byte_block_key_transform_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration write port
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [63:0]    i_cfg_data,
    // input byte transactions
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bbkt_pkg::t_in  i_in,
    // result transactions
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bbkt_pkg::t_out o_out
);

    // Controller decides what happens to each accepted transaction; the
    // datapath owns config, progress counters, the divider, swap buffer and
    // the output register. Input is taken whenever the sequencer is idle
    // and the output register is empty or draining this cycle.
    bbkt_pkg::t_cmd cmd;
    bbkt_pkg::t_sts sts;

    bbkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in.last_in),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    bbkt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
